// ----- src/force_sensor_impact_conditioner_defines.svh -----
`ifndef FORCE_SENSOR_IMPACT_CONDITIONER_DEFINES_SVH
`define FORCE_SENSOR_IMPACT_CONDITIONER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset
`define FSIC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset
`define FSIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fsic_pkg.sv -----
package fsic_pkg;

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int TIME_W    = 32;
    localparam int PRESS_W   = 7;
    localparam int HOLDOFF_W = 16;
    localparam int SUM_W     = 18;
    localparam int CNT_W     = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_THRESH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_MANUAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAP_MANUAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF         = 3'd4;

    // Operation codes
    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_MEASURE   = 1'b1;

    // Arithmetic constants
    localparam logic [SAMPLE_W-1:0]  FULL_SCALE      = 12'd4095;
    localparam logic [SAMPLE_W-1:0]  DEADBAND        = 12'd50;
    localparam logic [SAMPLE_W-1:0]  IMPACT_FLOOR    = 12'd500;
    localparam logic [SAMPLE_W-1:0]  STRAP_FLOOR     = 12'd50;
    localparam logic [SAMPLE_W-1:0]  STRAP_DIVISOR   = 12'd10;
    localparam logic [PRESS_W-1:0]   PRESSURE_MAX    = 7'd100;

    // Reset values
    localparam logic [SAMPLE_W-1:0]  IMPACT_RESET    = 12'd500;
    localparam logic [SAMPLE_W-1:0]  STRAP_RESET     = 12'd100;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET   = 16'd500;

    // Shared divider geometry: dividend covers 4095*100, divisor covers 12 bits
    localparam int DIV_DW = 19;
    localparam int DIV_VW = 12;
    localparam int DIV_CW = 5;
    localparam logic [DIV_CW-1:0] DIV_LAST = 5'(DIV_DW - 1);

    typedef struct packed {
        logic                operation;
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   time_ms;
    } t_in_item;

    typedef struct packed {
        logic [PRESS_W-1:0]  pressure;
        logic                impact;
        logic                strap_secure;
        logic                calibration_done;
        logic [SAMPLE_W-1:0] baseline;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_CAL_MEAN,
        ST_CAL_TENTH,
        ST_OUT
    } t_state;

endpackage

// ----- src/force_sensor_impact_conditioner.sv -----
// Force-sensor impact conditioner.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one sample
// transaction: a calibration sample or a measurement sample with its ms time.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
// result transaction per input: pressure, impact, strap status, calibration
// done flag and current baseline. Configuration writes arrive on
// i_cfg_valid / o_cfg_ready with a register index and data; always ready.
// One item is worked on at a time; o_in_ready is high only in idle.
// From accept to o_out_valid, a disabled block goes straight to output; a
// calibration sample that does not finish the baseline or a measurement below
// the deadband passes through evaluation only; a measurement that maps pressure
// adds one pass of the shared 19-step restoring divider; the calibration sample
// that finishes the baseline adds two passes (mean, then tenth, both on the
// same divider). A new item is accepted only once the last is loaded into a
// free output register. A result waits in the output register while the next
// item is accepted; a second result holds until the receiver takes the first.
// Reset (synchronous, active low) restores register and offset defaults,
// clears the baseline, calibration sum and count and last impact time.
module force_sensor_impact_conditioner
    import fsic_pkg::*;
#(
    parameter int CAL_SAMPLES = 50
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "force_sensor_impact_conditioner_defines.svh"

    // Configuration registers
    logic                 r_enable;
    logic                 r_manual;
    logic [SAMPLE_W-1:0]  r_imp_man;
    logic [SAMPLE_W-1:0]  r_strap_man;
    logic [HOLDOFF_W-1:0] r_holdoff;

    // Conditioner state
    logic [SAMPLE_W-1:0]  r_baseline;
    logic [SAMPLE_W-1:0]  r_imp_off;
    logic [SAMPLE_W-1:0]  r_strap_off;
    logic [TIME_W-1:0]    r_last_ms;
    logic [SUM_W-1:0]     r_cal_sum;
    logic [CNT_W-1:0]     r_cal_cnt;

    // Sequencer and item registers
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_item;
    t_out_item r_res;
    t_out_item r_out;
    logic      r_out_valid;

    t_div_req  div_req;
    t_div_rsp  div_rsp;

    logic [SAMPLE_W:0]   w_b13;
    logic [SAMPLE_W:0]   w_s13;
    logic [SAMPLE_W-1:0] w_ioff;
    logic [SAMPLE_W-1:0] w_soff;
    logic                w_press_on;
    logic [SAMPLE_W-1:0] w_diff;
    logic [DIV_DW-1:0]   w_num;
    logic [SAMPLE_W-1:0] w_den;
    logic                w_imp_hit;
    logic [TIME_W-1:0]   w_dt;
    logic                w_dt_ok;
    logic                w_strap;
    logic [SUM_W-1:0]    w_sum_n;
    logic [CNT_W-1:0]    w_cnt_n;
    logic                w_cal_last;
    logic                w_is_cal;
    logic [SAMPLE_W-1:0] w_mean;
    logic [SAMPLE_W-1:0] w_half;
    logic [SAMPLE_W-1:0] w_tenth;
    logic [PRESS_W-1:0]  w_press;
    logic                w_out_free;
    logic                w_load_out;
    logic                w_accept;

    fsic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration writes, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_manual    <= 1'b0;
            r_imp_man   <= IMPACT_RESET;
            r_strap_man <= STRAP_RESET;
            r_holdoff   <= HOLDOFF_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SENSOR_ENABLE: r_enable    <= i_cfg_data[0];
                CFG_MANUAL_THRESH: r_manual    <= i_cfg_data[0];
                CFG_IMPACT_MANUAL: r_imp_man   <= i_cfg_data[SAMPLE_W-1:0];
                CFG_STRAP_MANUAL:  r_strap_man <= i_cfg_data[SAMPLE_W-1:0];
                CFG_HOLDOFF:       r_holdoff   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Measurement compares and pressure operands
    always_comb begin
        w_is_cal   = r_item.operation == OP_CALIBRATE;
        w_b13      = {1'b0, r_baseline};
        w_s13      = {1'b0, r_item.sample};
        w_ioff     = r_manual ? r_imp_man : r_imp_off;
        w_soff     = r_manual ? r_strap_man : r_strap_off;
        w_press_on = (w_s13 >= w_b13 + {1'b0, DEADBAND}) && (r_baseline != FULL_SCALE);
        w_diff     = r_item.sample - r_baseline;
        w_num      = DIV_DW'(w_diff) * DIV_DW'(PRESSURE_MAX);
        w_den      = FULL_SCALE - r_baseline;
        w_imp_hit  = w_s13 > w_b13 + {1'b0, w_ioff};
        w_dt       = r_item.time_ms - r_last_ms;
        w_dt_ok    = w_dt > {{(TIME_W-HOLDOFF_W){1'b0}}, r_holdoff};
        w_strap    = w_s13 >= w_b13 + {1'b0, w_soff};
    end

    // Calibration accumulate and offset derivation
    always_comb begin
        w_sum_n    = r_cal_sum + SUM_W'(r_item.sample);
        w_cnt_n    = r_cal_cnt + 1'b1;
        w_cal_last = w_cnt_n >= CNT_W'(CAL_SAMPLES);
        w_mean     = div_rsp.quotient[SAMPLE_W-1:0];
        w_half     = {1'b0, w_mean[SAMPLE_W-1:1]};
        w_tenth    = div_rsp.quotient[SAMPLE_W-1:0];
        w_press    = (div_rsp.quotient > DIV_DW'(PRESSURE_MAX)) ? PRESSURE_MAX
                                                                : div_rsp.quotient[PRESS_W-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = r_enable ? ST_EVAL : ST_OUT;
            end
            ST_EVAL: begin
                if (w_is_cal) n_state = w_cal_last ? ST_CAL_MEAN : ST_OUT;
                else          n_state = w_press_on ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (div_rsp.done) n_state = ST_OUT;
            end
            ST_CAL_MEAN: begin
                if (div_rsp.done) n_state = ST_CAL_TENTH;
            end
            ST_CAL_TENTH: begin
                if (div_rsp.done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshakes and divider requests
    always_comb begin
        o_in_ready       = 1'b0;
        w_out_free       = !r_out_valid || i_out_ready;
        w_load_out       = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = w_num;
        div_req.divisor  = w_den;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_EVAL: begin
                if (w_is_cal) begin
                    div_req.start    = w_cal_last;
                    div_req.dividend = DIV_DW'(w_sum_n);
                    div_req.divisor  = DIV_VW'(CAL_SAMPLES);
                end else begin
                    div_req.start = w_press_on;
                end
            end
            ST_CAL_MEAN: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = DIV_DW'(w_mean);
                div_req.divisor  = STRAP_DIVISOR;
            end
            ST_OUT: w_load_out = w_out_free;
            default: begin
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_baseline  <= '0;
            r_imp_off   <= IMPACT_RESET;
            r_strap_off <= STRAP_RESET;
            r_last_ms   <= '0;
            r_cal_sum   <= '0;
            r_cal_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load_out)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_EVAL: begin
                    if (w_is_cal) begin
                        r_cal_sum <= w_cal_last ? '0 : w_sum_n;
                        r_cal_cnt <= w_cal_last ? '0 : w_cnt_n;
                    end else if (w_imp_hit && w_dt_ok) begin
                        r_last_ms <= r_item.time_ms;
                    end
                end
                ST_CAL_MEAN: begin
                    if (div_rsp.done) begin
                        r_baseline <= w_mean;
                        r_imp_off  <= (w_half > IMPACT_FLOOR) ? w_half : IMPACT_FLOOR;
                    end
                end
                ST_CAL_TENTH: begin
                    if (div_rsp.done) begin
                        r_strap_off <= (w_tenth > STRAP_FLOOR) ? w_tenth : STRAP_FLOOR;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Item capture, working result and output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
            r_res  <= '0;
        end
        unique case (r_state)
            ST_EVAL: begin
                r_res.baseline <= r_baseline;
                if (!w_is_cal) begin
                    r_res.impact       <= w_imp_hit && w_dt_ok;
                    r_res.strap_secure <= w_strap;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) r_res.pressure <= w_press;
            end
            ST_CAL_TENTH: begin
                if (div_rsp.done) begin
                    r_res.calibration_done <= 1'b1;
                    r_res.baseline         <= r_baseline;
                end
            end
            default: begin
            end
        endcase
        if (w_load_out) r_out <= r_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `FSIC_ASSERT_IMPL(a_press_range, i_clk, i_rst_n, o_out_valid,
        o_out_data.pressure <= PRESSURE_MAX, "pressure above full scale")
    `FSIC_ASSERT_IMPL(a_cal_clean, i_clk, i_rst_n,
        o_out_valid && o_out_data.calibration_done,
        o_out_data.pressure == '0 && !o_out_data.impact && !o_out_data.strap_secure,
        "calibration result carries measurement fields")
    `FSIC_ASSERT_IMPL(a_div_idle, i_clk, i_rst_n, r_state == ST_IDLE,
        !div_rsp.busy, "divider busy while sequencer idle")
    `FSIC_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, w_accept && r_enable,
        r_state == ST_EVAL, "accepted item did not enter evaluation")

endmodule

// ----- src/fsic_div.sv -----
module fsic_div
    import fsic_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_VW-1:0] r_divisor;

    logic [DIV_VW:0]   w_trial;
    logic              w_ge;
    logic [DIV_VW:0]   w_diff;
    logic [DIV_VW-1:0] n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_DW-1]};
        w_ge    = w_trial >= {1'b0, r_divisor};
        w_diff  = w_trial - {1'b0, r_divisor};
        n_rem   = w_ge ? w_diff[DIV_VW-1:0] : w_trial[DIV_VW-1:0];
    end

    // Control: busy for DIV_DW steps, done pulse after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_DW-2:0], w_ge};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- verif/force_sensor_impact_conditioner_tb.sv -----
`timescale 1ns / 1ps

module force_sensor_impact_conditioner_tb;
    import fsic_pkg::*;

    localparam int CAL_COUNT      = 50;
    localparam int MAX_IDLE       = 14;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_CYCLES     = 60;

    typedef struct {
        t_in_item    data;
        int unsigned gap;
    } t_queued_sample;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // DUT ports
    logic                  in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              in_data   = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Register mirror
    logic                 cfg_enable;
    logic                 cfg_manual;
    logic [SAMPLE_W-1:0]  cfg_impact_man;
    logic [SAMPLE_W-1:0]  cfg_strap_man;
    logic [HOLDOFF_W-1:0] cfg_holdoff;

    // Conditioner state mirror
    logic [SAMPLE_W-1:0] base_level;
    logic [SAMPLE_W-1:0] impact_off;
    logic [SAMPLE_W-1:0] strap_off;
    logic [TIME_W-1:0]   last_hit_ms;
    logic [SUM_W-1:0]    cal_sum;
    logic [CNT_W-1:0]    cal_count;

    // Stimulus and scoreboard bookkeeping
    t_queued_sample sample_queue[$];
    t_out_item      expected_results[$];
    int unsigned    items_queued  = 0;
    int unsigned    results_seen  = 0;
    int unsigned    error_count   = 0;
    int unsigned    hold_reqs     = 0;
    int unsigned    hold_served   = 0;
    bit             tx_bursty     = 1'b1;
    bit             rx_bursty     = 1'b1;
    bit             gen_enabled   = 1'b0;
    int             cal_pending   = 0;
    logic [TIME_W-1:0] cur_ms     = '0;

    // Driver / monitor / watchdog counters
    int unsigned    gap_count     = 0;
    int unsigned    stall_count   = 0;
    int unsigned    hold_count    = 0;
    int unsigned    quiet_cycles  = 0;

    force_sensor_impact_conditioner #(
        .CAL_SAMPLES(CAL_COUNT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predict one result and advance the mirrored state
    function automatic t_out_item condition_sample(input t_in_item item);
        t_out_item   res;
        int unsigned b, ioff, soff, s, mean, p;
        logic [TIME_W-1:0] dt;
        res = '0;
        if (!cfg_enable) return res;
        s = item.sample;
        if (item.operation == OP_CALIBRATE) begin
            cal_sum   = cal_sum + item.sample;
            cal_count = cal_count + 1'b1;
            if (cal_count >= CAL_COUNT) begin
                mean       = cal_sum / CAL_COUNT;
                base_level = mean[SAMPLE_W-1:0];
                impact_off = SAMPLE_W'((base_level / 2 > IMPACT_FLOOR) ?
                                       base_level / 2 : IMPACT_FLOOR);
                strap_off  = (base_level / STRAP_DIVISOR > STRAP_FLOOR) ?
                             base_level / STRAP_DIVISOR : STRAP_FLOOR;
                cal_sum    = '0;
                cal_count  = '0;
                res.calibration_done = 1'b1;
            end
        end else begin
            b    = base_level;
            ioff = cfg_manual ? cfg_impact_man : impact_off;
            soff = cfg_manual ? cfg_strap_man : strap_off;
            // pressure mapping with deadband; full-scale baseline guarded
            if (s >= b + DEADBAND && b != FULL_SCALE) begin
                p = ((s - b) * 100) / (FULL_SCALE - b);
                if (p > PRESSURE_MAX) p = PRESSURE_MAX;
                res.pressure = p[PRESS_W-1:0];
            end
            // impact with hold-off, time wraps mod 2^32
            if (s > b + ioff) begin
                dt = item.time_ms - last_hit_ms;
                if (dt > cfg_holdoff) begin
                    last_hit_ms = item.time_ms;
                    res.impact  = 1'b1;
                end
            end
            res.strap_secure = (s >= b + soff);
        end
        res.baseline = base_level;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic int clip12(input int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    // Driver: presents queued samples, records expectations on acceptance
    always @(posedge i_clk) begin
        logic           next_valid;
        t_queued_sample pend;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_count = 0;
        end else begin
            next_valid = in_valid;
            if (in_valid && o_in_ready) begin
                expected_results.push_back(condition_sample(in_data));
                next_valid = 1'b0;
            end
            if (!next_valid && sample_queue.size() > 0) begin
                if (gap_count < sample_queue[0].gap) begin
                    gap_count++;
                end else begin
                    pend = sample_queue.pop_front();
                    in_data <= pend.data;
                    next_valid = 1'b1;
                    gap_count = 0;
                end
            end
            in_valid <= next_valid;
        end
    end

    // Monitor: random stalls, long hold-off on request, field checks
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_count = 0;
            hold_count  = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result transaction, expected none, actual %h",
                             $time, o_out_data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("pressure", want.pressure, o_out_data.pressure);
                    check_field("impact", want.impact, o_out_data.impact);
                    check_field("strap_secure", want.strap_secure, o_out_data.strap_secure);
                    check_field("calibration_done", want.calibration_done,
                                o_out_data.calibration_done);
                    check_field("baseline", want.baseline, o_out_data.baseline);
                end
                stall_count = rx_bursty ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (hold_reqs != hold_served && hold_count == 0) begin
                hold_served++;
                hold_count = LONG_HOLD;
            end
            out_ready <= (hold_count == 0 && stall_count == 0);
            if (hold_count > 0) hold_count--;
            else if (stall_count > 0) stall_count--;
        end
    end

    // Watchdog: ends the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SENSOR_ENABLE: cfg_enable     = val[0];
            CFG_MANUAL_THRESH: cfg_manual     = val[0];
            CFG_IMPACT_MANUAL: cfg_impact_man = val[SAMPLE_W-1:0];
            CFG_STRAP_MANUAL:  cfg_strap_man  = val[SAMPLE_W-1:0];
            CFG_HOLDOFF:       cfg_holdoff    = val[HOLDOFF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_sample(input logic op, input int s, input logic [TIME_W-1:0] t);
        t_queued_sample q;
        q.data.operation = op;
        q.data.sample    = s[SAMPLE_W-1:0];
        q.data.time_ms   = t;
        q.gap            = tx_bursty ? $urandom_range(0, MAX_IDLE) : 0;
        sample_queue.push_back(q);
        items_queued++;
        if (gen_enabled && op == OP_CALIBRATE) cal_pending = (cal_pending + 1) % CAL_COUNT;
    endtask

    // Wait until every queued sample has produced its result
    task automatic wait_drain();
        do @(posedge i_clk); while (results_seen < items_queued);
    endtask

    function automatic logic [TIME_W-1:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)      cur_ms = cur_ms + $urandom_range(0, 700);
        else if (r < 95) cur_ms = cur_ms + $urandom_range(0, 70000);
        else             cur_ms = $urandom();
        return cur_ms;
    endfunction

    function automatic int pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 0;
        if (r < 14) return 4095;
        if (r < 55) return $urandom_range(0, 1500);
        return $urandom_range(0, 4095);
    endfunction

    // Measurement sample aimed at the interesting boundaries around a level
    function automatic int measure_sample(input int lvl);
        int jit;
        jit = int'($urandom_range(0, 4)) - 2;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 4095);
            1: return clip12(lvl + DEADBAND + jit);
            2: return clip12(lvl + ((lvl / 2 > 500) ? lvl / 2 : 500) + jit);
            3: return clip12(lvl + ((lvl / 10 > 50) ? lvl / 10 : 50) + jit);
            4: return clip12(lvl + cfg_impact_man + jit);
            5: return clip12(lvl + cfg_strap_man + jit);
            6: return $urandom_range(0, 1) ? 4095 : 0;
            default: return clip12(lvl - 100 + int'($urandom_range(0, 1600)));
        endcase
    endfunction

    // Mostly full calibration bursts followed by measurements; some noise
    task automatic gen_traffic(input int count, input int forced_level);
        int made, lvl, noise, k, n, kind;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 70 || forced_level >= 0) begin
                if (forced_level >= 0) begin
                    lvl = forced_level;
                    noise = 0;
                    forced_level = -1;
                end else begin
                    lvl = pick_level();
                    noise = $urandom_range(0, 8);
                end
                n = gen_enabled ? CAL_COUNT - cal_pending : CAL_COUNT;
                for (k = 0; k < n; k++)
                    push_sample(OP_CALIBRATE,
                                clip12(lvl - noise + int'($urandom_range(0, 2 * noise))),
                                next_time());
                made += n;
                n = $urandom_range(5, 40);
                for (k = 0; k < n; k++)
                    push_sample(OP_MEASURE, measure_sample(lvl), next_time());
                made += n;
            end else if (kind < 85) begin
                // broken calibration: partial burst, then measurements
                lvl = pick_level();
                n = $urandom_range(1, CAL_COUNT - 1);
                for (k = 0; k < n; k++)
                    push_sample(OP_CALIBRATE, clip12(lvl + int'($urandom_range(0, 6)) - 3),
                                next_time());
                made += n;
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++)
                    push_sample(OP_MEASURE, measure_sample(lvl), next_time());
                made += n;
            end else begin
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++)
                    push_sample($urandom_range(0, 1) ? OP_MEASURE : OP_CALIBRATE,
                                $urandom_range(0, 4095), $urandom());
                made += n;
            end
        end
    endtask

    task automatic run_phase(input bit en, input bit manual, input int imp, input int strap,
                             input int holdoff, input int count, input int level,
                             input bit tx_idle, input bit rx_idle, input bit long_hold);
        write_reg(CFG_SENSOR_ENABLE, {15'($urandom), en});
        write_reg(CFG_MANUAL_THRESH, {15'($urandom), manual});
        write_reg(CFG_IMPACT_MANUAL, {4'($urandom), imp[SAMPLE_W-1:0]});
        write_reg(CFG_STRAP_MANUAL, {4'($urandom), strap[SAMPLE_W-1:0]});
        write_reg(CFG_HOLDOFF, holdoff[HOLDOFF_W-1:0]);
        tx_bursty   = tx_idle;
        rx_bursty   = rx_idle;
        gen_enabled = en;
        if (long_hold) hold_reqs++;
        gen_traffic(count, level);
        wait_drain();
    endtask

    initial begin
        int idx;
        cfg_enable     = 1'b0;
        cfg_manual     = 1'b0;
        cfg_impact_man = IMPACT_RESET;
        cfg_strap_man  = STRAP_RESET;
        cfg_holdoff    = HOLDOFF_RESET;
        base_level     = '0;
        impact_off     = IMPACT_RESET;
        strap_off      = STRAP_RESET;
        last_hit_ms    = '0;
        cal_sum        = '0;
        cal_count      = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled after reset: every field zero
        push_sample(OP_MEASURE, 4095, 32'd1000);
        push_sample(OP_CALIBRATE, 4095, 32'd1010);
        wait_drain();

        write_reg(CFG_SENSOR_ENABLE, 16'd1);
        gen_enabled = 1'b1;
        // Zero baseline: deadband edges, full scale, early-time hold-off
        push_sample(OP_MEASURE, 0, 32'd0);
        push_sample(OP_MEASURE, 49, 32'd10);
        push_sample(OP_MEASURE, 50, 32'd20);
        push_sample(OP_MEASURE, 4095, 32'd100);
        push_sample(OP_MEASURE, 4095, 32'd500);
        push_sample(OP_MEASURE, 4095, 32'd501);
        push_sample(OP_MEASURE, 4095, 32'd1001);
        push_sample(OP_MEASURE, 4095, 32'd1002);
        push_sample(OP_MEASURE, 501, 32'd5000);
        push_sample(OP_MEASURE, 500, 32'd9000);
        push_sample(OP_MEASURE, 99, 32'd9001);
        push_sample(OP_MEASURE, 100, 32'd9002);
        // Time wrap around 2^32
        push_sample(OP_MEASURE, 4095, 32'hFFFF_FFFF);
        push_sample(OP_MEASURE, 4095, 32'd3);
        push_sample(OP_MEASURE, 4095, 32'd600);
        // Measurement in the middle of a calibration keeps the partial sum
        push_sample(OP_CALIBRATE, 4095, 32'd700);
        push_sample(OP_CALIBRATE, 0, 32'd710);
        push_sample(OP_CALIBRATE, 2048, 32'd720);
        push_sample(OP_MEASURE, 2000, 32'd2000);
        wait_drain();
        cur_ms = 32'd3000;

        // Derived thresholds, zero baseline first
        run_phase(1'b1, 1'b0, 500, 100, 500, 300, 0, 1'b1, 1'b1, 1'b0);
        // Manual thresholds at zero, no hold-off, no idling, long receiver stall
        run_phase(1'b1, 1'b1, 0, 0, 0, 250, -1, 1'b0, 1'b0, 1'b1);
        // Manual thresholds at full scale, longest hold-off
        run_phase(1'b1, 1'b1, 4095, 4095, 65535, 250, -1, 1'b1, 1'b1, 1'b0);
        // Disabled
        run_phase(1'b0, 1'b0, 300, 200, 100, 40, -1, 1'b1, 1'b0, 1'b0);
        // Full-scale baseline, time close to wrapping
        cur_ms = 32'hFFFF_F000;
        run_phase(1'b1, 1'b0, 1000, 300, $urandom_range(0, 1000), 300, 4095,
                  1'b1, 1'b1, 1'b0);

        // Unused register indexes are ignored
        for (idx = CFG_HOLDOFF + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(idx[CFG_IDX_W-1:0], 16'($urandom));

        repeat (3) begin
            run_phase(1'b1, 1'($urandom), $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(0, 65535),
                      280, -1, 1'($urandom), 1'($urandom), 1'b0);
        end

        wait_drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
